/* rtl/bfsp_pkg.sv */
// shared types and constants for the bellman-ford shortest path unit
package bfsp_pkg;

	// fixed field widths of the channels
	localparam int VTX_BITS      = 6;
	localparam int DIST_BITS     = 32;
	localparam int CNT_BITS      = 7;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_VERTEX = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT  = 2'd1;

	// configuration reset values
	localparam logic [VTX_BITS-1:0] SOURCE_RESET = 6'd0;
	localparam logic [CNT_BITS-1:0] COUNT_RESET  = 7'd5;

	// saturation limits of a stored distance
	localparam logic [DIST_BITS-1:0] DIST_MAX = 32'h7fff_ffff;
	localparam logic [DIST_BITS-1:0] DIST_MIN = 32'h8000_0000;

	// configuration as seen by the controller
	typedef struct packed {
		logic [VTX_BITS-1:0] source_vertex;
		logic [CNT_BITS-1:0] vertex_count;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [VTX_BITS-1:0]  vertex;
		logic [DIST_BITS-1:0] distance;
		logic                 reachable;
		logic [VTX_BITS-1:0]  predecessor;
		logic                 negative_cycle;
		logic                 last_result;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS,
		ST_FETCH,
		ST_RELAX,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_SHOW
	} state_t;

endpackage

/* rtl/bfsp_if.sv */
// channel interfaces of the bellman-ford shortest path unit

// edge input channel
interface bfsp_edge_if #(
	parameter int WEIGHT_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [bfsp_pkg::VTX_BITS-1:0] edge_from;
	logic [bfsp_pkg::VTX_BITS-1:0] edge_to;
	logic signed [WEIGHT_BITS-1:0] edge_weight;
	logic                          last_edge;

	modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
	modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

// result output channel
interface bfsp_result_if;
	logic                           valid;
	logic                           ready;
	logic [bfsp_pkg::VTX_BITS-1:0]  vertex;
	logic signed [bfsp_pkg::DIST_BITS-1:0] distance;
	logic                           reachable;
	logic [bfsp_pkg::VTX_BITS-1:0]  predecessor;
	logic                           negative_cycle;
	logic                           last_result;

	modport source (output valid, vertex, distance, reachable, predecessor, negative_cycle,
		last_result, input ready);
	modport sink (input valid, vertex, distance, reachable, predecessor, negative_cycle,
		last_result, output ready);
endinterface

// configuration write channel
interface bfsp_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bfsp_pkg::CFG_IDX_BITS-1:0]  index;
	logic [bfsp_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bfsp_edge_mem.sv */
// edge store: one write port, one registered read port
module bfsp_edge_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 28
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bfsp_vertex_mem.sv */
// vertex store: distance and predecessor, one write port, two registered read ports
module bfsp_vertex_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [bfsp_pkg::DIST_BITS-1:0] wdist,
	input  logic [AW-1:0]                  wpred,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr_a,
	input  logic [AW-1:0]                  raddr_b,
	output logic [bfsp_pkg::DIST_BITS-1:0] rdist_a,
	output logic [AW-1:0]                  rpred_a,
	output logic [bfsp_pkg::DIST_BITS-1:0] rdist_b
);

	logic [bfsp_pkg::DIST_BITS-1:0] dist_mem [DEPTH];
	logic [AW-1:0]                  pred_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			dist_mem[waddr] <= wdist;
			pred_mem[waddr] <= wpred;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdist_a <= dist_mem[raddr_a];
			rpred_a <= pred_mem[raddr_a];
			rdist_b <= dist_mem[raddr_b];
		end
	end

endmodule

/* rtl/bfsp_ctrl.sv */
// sequencer and relaxation datapath of the shortest path unit
module bfsp_ctrl #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16,
	localparam int VIW = $clog2(MAX_VERTICES),
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int EW  = 2 * VIW + WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfsp_pkg::cfg_t                 cfg,
	// edge channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bfsp_pkg::VTX_BITS-1:0]  in_from,
	input  logic [bfsp_pkg::VTX_BITS-1:0]  in_to,
	input  logic [WEIGHT_BITS-1:0]         in_weight,
	input  logic                           in_last,
	// result channel
	output logic                           res_valid,
	input  logic                           res_ready,
	output bfsp_pkg::result_t              res,
	// edge store
	output logic                           edge_we,
	output logic [EAW-1:0]                 edge_waddr,
	output logic [EW-1:0]                  edge_wdata,
	output logic                           edge_re,
	output logic [EAW-1:0]                 edge_raddr,
	input  logic [EW-1:0]                  edge_rdata,
	// vertex store
	output logic                           vtx_we,
	output logic [VIW-1:0]                 vtx_waddr,
	output logic [bfsp_pkg::DIST_BITS-1:0] vtx_wdist,
	output logic [VIW-1:0]                 vtx_wpred,
	output logic                           vtx_re,
	output logic [VIW-1:0]                 vtx_raddr_a,
	output logic [VIW-1:0]                 vtx_raddr_b,
	input  logic [bfsp_pkg::DIST_BITS-1:0] vtx_rdist_a,
	input  logic [VIW-1:0]                 vtx_rpred_a,
	input  logic [bfsp_pkg::DIST_BITS-1:0] vtx_rdist_b
);

	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int CW  = bfsp_pkg::CNT_BITS;
	localparam int DW  = bfsp_pkg::DIST_BITS;

	bfsp_pkg::state_t state_q, state_d;

	logic [ECW-1:0]          count_q;
	logic [ECW-1:0]          e_q;
	logic [CW-1:0]           pass_q;
	logic                    check_q;
	logic [VIW-1:0]          v_q;
	logic [MAX_VERTICES-1:0] reach_q;

	logic [CW-1:0]  nv;
	logic           src_ok;
	logic           in_ok;
	logic           accept;
	logic           start;
	logic           pass_end;
	logic [VIW-1:0] e_from;
	logic [VIW-1:0] e_to;
	logic [WEIGHT_BITS-1:0] e_w;
	logic           edge_ok;
	logic [DW:0]    wext;
	logic [DW:0]    sum;
	logic           lt;
	logic           improve;
	logic [DW-1:0]  sum_sat;
	logic           v_last;

	// effective vertex count
	always_comb begin
		priority if (cfg.vertex_count == '0) begin
			nv = CW'(1);
		end else if (cfg.vertex_count > CW'(MAX_VERTICES)) begin
			nv = CW'(MAX_VERTICES);
		end else begin
			nv = cfg.vertex_count;
		end
	end

	// load side checks
	assign src_ok   = CW'(cfg.source_vertex) < nv;
	assign in_ok    = (CW'(in_from) < nv) && (CW'(in_to) < nv) && (count_q != ECW'(MAX_EDGES));
	assign accept   = in_valid && in_ready;
	assign start    = accept && in_last;
	assign pass_end = (e_q == count_q);

	// stored edge fields
	assign e_from = edge_rdata[EW-1 -: VIW];
	assign e_to   = edge_rdata[EW-1-VIW -: VIW];
	assign e_w    = edge_rdata[WEIGHT_BITS-1:0];

	// relaxation: exact sum, compare, saturate
	assign edge_ok = (CW'(e_from) < nv) && (CW'(e_to) < nv);
	assign wext    = {{(DW + 1 - WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w};
	assign sum     = {vtx_rdist_a[DW-1], vtx_rdist_a} + wext;
	assign lt      = $signed(sum) < $signed({vtx_rdist_b[DW-1], vtx_rdist_b});
	assign improve = edge_ok && reach_q[e_from] && (!reach_q[e_to] || lt);

	always_comb begin
		priority if (sum[DW] != sum[DW-1]) begin
			sum_sat = sum[DW] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
		end else begin
			sum_sat = sum[DW-1:0];
		end
	end

	assign v_last = (CW'(v_q) + CW'(1)) == nv;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfsp_pkg::ST_LOAD: begin
				if (start) begin
					state_d = bfsp_pkg::ST_PASS;
				end
			end
			bfsp_pkg::ST_PASS: begin
				if (!pass_end) begin
					state_d = bfsp_pkg::ST_FETCH;
				end else if (check_q) begin
					state_d = bfsp_pkg::ST_OUT_RD;
				end
			end
			bfsp_pkg::ST_FETCH: begin
				state_d = bfsp_pkg::ST_RELAX;
			end
			bfsp_pkg::ST_RELAX: begin
				if (check_q && improve) begin
					state_d = bfsp_pkg::ST_OUT_SHOW;
				end else begin
					state_d = bfsp_pkg::ST_PASS;
				end
			end
			bfsp_pkg::ST_OUT_RD: begin
				state_d = bfsp_pkg::ST_OUT_LOAD;
			end
			bfsp_pkg::ST_OUT_LOAD: begin
				state_d = bfsp_pkg::ST_OUT_SHOW;
			end
			bfsp_pkg::ST_OUT_SHOW: begin
				if (res_ready) begin
					state_d = res.last_result ? bfsp_pkg::ST_LOAD : bfsp_pkg::ST_OUT_RD;
				end
			end
			default: begin
				state_d = bfsp_pkg::ST_LOAD;
			end
		endcase
	end

	// memory and handshake controls
	always_comb begin
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		edge_we     = 1'b0;
		edge_re     = 1'b0;
		vtx_we      = 1'b0;
		vtx_re      = 1'b0;
		vtx_waddr   = e_to;
		vtx_wdist   = sum_sat;
		vtx_wpred   = e_from;
		vtx_raddr_a = e_from;
		vtx_raddr_b = e_to;
		unique case (state_q)
			bfsp_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				edge_we  = accept && in_ok;
				// seed the source entry when the run starts
				if (start && src_ok) begin
					vtx_we    = 1'b1;
					vtx_waddr = cfg.source_vertex[VIW-1:0];
					vtx_wdist = '0;
					vtx_wpred = cfg.source_vertex[VIW-1:0];
				end
			end
			bfsp_pkg::ST_PASS: begin
				edge_re = !pass_end;
			end
			bfsp_pkg::ST_FETCH: begin
				vtx_re = 1'b1;
			end
			bfsp_pkg::ST_RELAX: begin
				vtx_we = improve && !check_q;
			end
			bfsp_pkg::ST_OUT_RD: begin
				vtx_re      = 1'b1;
				vtx_raddr_a = v_q;
			end
			bfsp_pkg::ST_OUT_LOAD: begin
			end
			bfsp_pkg::ST_OUT_SHOW: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign edge_waddr = count_q[EAW-1:0];
	assign edge_wdata = {in_from[VIW-1:0], in_to[VIW-1:0], in_weight};
	assign edge_raddr = e_q[EAW-1:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsp_pkg::ST_LOAD;
			count_q <= '0;
			e_q     <= '0;
			pass_q  <= '0;
			check_q <= 1'b0;
			v_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				bfsp_pkg::ST_LOAD: begin
					if (accept && in_ok) begin
						count_q <= count_q + ECW'(1);
					end
					if (start) begin
						e_q     <= '0;
						pass_q  <= '0;
						check_q <= (nv == CW'(1));
					end
				end
				bfsp_pkg::ST_PASS: begin
					if (pass_end) begin
						if (check_q) begin
							v_q     <= '0;
							count_q <= '0;
						end else begin
							pass_q  <= pass_q + CW'(1);
							check_q <= (pass_q + CW'(1)) == (nv - CW'(1));
							e_q     <= '0;
						end
					end
				end
				bfsp_pkg::ST_RELAX: begin
					if (check_q && improve) begin
						count_q <= '0;
					end else begin
						e_q <= e_q + ECW'(1);
					end
				end
				bfsp_pkg::ST_OUT_SHOW: begin
					if (res_ready && !res.last_result) begin
						v_q <= v_q + VIW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// reached flags and result register
	always_ff @(posedge clk) begin
		if (state_q == bfsp_pkg::ST_LOAD && start) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				reach_q[i] <= src_ok && (VIW'(i) == cfg.source_vertex[VIW-1:0]);
			end
		end else if (state_q == bfsp_pkg::ST_RELAX && improve && !check_q) begin
			reach_q[e_to] <= 1'b1;
		end
		if (state_q == bfsp_pkg::ST_RELAX && check_q && improve) begin
			res <= '{vertex: '0, distance: '0, reachable: 1'b0, predecessor: '0,
				negative_cycle: 1'b1, last_result: 1'b1};
		end else if (state_q == bfsp_pkg::ST_OUT_LOAD) begin
			res.vertex         <= bfsp_pkg::VTX_BITS'(v_q);
			res.distance       <= reach_q[v_q] ? vtx_rdist_a : '0;
			res.reachable      <= reach_q[v_q];
			res.predecessor    <= bfsp_pkg::VTX_BITS'(reach_q[v_q] ? vtx_rpred_a : v_q);
			res.negative_cycle <= 1'b0;
			res.last_result    <= v_last;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ECW'(MAX_EDGES))
		else $error("edge count above capacity");
	a_check_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::ST_RELAX && check_q) |-> !vtx_we)
		else $error("vertex store written during cycle check");
	a_edge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::ST_FETCH || state_q == bfsp_pkg::ST_RELAX) |-> e_q < count_q)
		else $error("edge index past stored edges");
	a_neg_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.negative_cycle) |-> (res.last_result && !res.reachable))
		else $error("negative cycle item not final");
`endif

endmodule

/* rtl/bellman_ford_shortest_paths_unit.sv */
// top level of the bellman-ford single-source shortest path unit
//
// channels: edges (sink) takes one directed weighted edge per item, last_edge
// on the final one; results (source) gives one item per vertex, or a single
// item with negative_cycle set; cfg (sink) writes source_vertex (index 0) and
// vertex_count (index 1), always ready; the user must write cfg only while the
// unit is idle, as the block does not enforce this. edges load at one item per
// cycle while no run is in progress. after the last edge each relaxation pass
// reads every stored edge in turn: edge store read, vertex store read at both
// ends, then compare and write back; vertex_count-1 passes run, then one check
// pass that stops at the first improvable edge. each result item is read from
// the vertex store, loaded into the result register and then shown until taken.
// the edge channel is not ready from the last edge until the final result is
// taken; a stalled receiver holds the result register and the run waits.
// reset clears the edge count and sets source 0, vertex count 5; no clearing
// pass is needed, as reached flags are flip-flops set at the start of a run.
module bellman_ford_shortest_paths_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	bfsp_cfg_if.sink       cfg,
	bfsp_edge_if.sink      edges,
	bfsp_result_if.source  results
);

	localparam int VIW = $clog2(MAX_VERTICES);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = 2 * VIW + WEIGHT_BITS;

	logic [bfsp_pkg::VTX_BITS-1:0] source_vertex_q;
	logic [bfsp_pkg::CNT_BITS-1:0] vertex_count_q;
	bfsp_pkg::cfg_t                cfg_cur;
	bfsp_pkg::result_t             res;

	logic                           edge_we;
	logic [EAW-1:0]                 edge_waddr;
	logic [EW-1:0]                  edge_wdata;
	logic                           edge_re;
	logic [EAW-1:0]                 edge_raddr;
	logic [EW-1:0]                  edge_rdata;
	logic                           vtx_we;
	logic [VIW-1:0]                 vtx_waddr;
	logic [bfsp_pkg::DIST_BITS-1:0] vtx_wdist;
	logic [VIW-1:0]                 vtx_wpred;
	logic                           vtx_re;
	logic [VIW-1:0]                 vtx_raddr_a;
	logic [VIW-1:0]                 vtx_raddr_b;
	logic [bfsp_pkg::DIST_BITS-1:0] vtx_rdist_a;
	logic [VIW-1:0]                 vtx_rpred_a;
	logic [bfsp_pkg::DIST_BITS-1:0] vtx_rdist_b;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_vertex_q <= bfsp_pkg::SOURCE_RESET;
			vertex_count_q  <= bfsp_pkg::COUNT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == bfsp_pkg::CFG_SOURCE_VERTEX) begin
				source_vertex_q <= cfg.data[bfsp_pkg::VTX_BITS-1:0];
			end
			if (cfg.index == bfsp_pkg::CFG_VERTEX_COUNT) begin
				vertex_count_q <= cfg.data[bfsp_pkg::CNT_BITS-1:0];
			end
		end
	end

	assign cfg_cur.source_vertex = source_vertex_q;
	assign cfg_cur.vertex_count  = vertex_count_q;

	// result channel fields
	assign results.vertex         = res.vertex;
	assign results.distance       = res.distance;
	assign results.reachable      = res.reachable;
	assign results.predecessor    = res.predecessor;
	assign results.negative_cycle = res.negative_cycle;
	assign results.last_result    = res.last_result;

	bfsp_edge_mem #(
		.DEPTH (MAX_EDGES),
		.AW    (EAW),
		.DW    (EW)
	) u_edge_mem (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.re    (edge_re),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	bfsp_vertex_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (VIW)
	) u_vertex_mem (
		.clk     (clk),
		.we      (vtx_we),
		.waddr   (vtx_waddr),
		.wdist   (vtx_wdist),
		.wpred   (vtx_wpred),
		.re      (vtx_re),
		.raddr_a (vtx_raddr_a),
		.raddr_b (vtx_raddr_b),
		.rdist_a (vtx_rdist_a),
		.rpred_a (vtx_rpred_a),
		.rdist_b (vtx_rdist_b)
	);

	bfsp_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_cur),
		.in_valid    (edges.valid),
		.in_ready    (edges.ready),
		.in_from     (edges.edge_from),
		.in_to       (edges.edge_to),
		.in_weight   (edges.edge_weight),
		.in_last     (edges.last_edge),
		.res_valid   (results.valid),
		.res_ready   (results.ready),
		.res         (res),
		.edge_we     (edge_we),
		.edge_waddr  (edge_waddr),
		.edge_wdata  (edge_wdata),
		.edge_re     (edge_re),
		.edge_raddr  (edge_raddr),
		.edge_rdata  (edge_rdata),
		.vtx_we      (vtx_we),
		.vtx_waddr   (vtx_waddr),
		.vtx_wdist   (vtx_wdist),
		.vtx_wpred   (vtx_wpred),
		.vtx_re      (vtx_re),
		.vtx_raddr_a (vtx_raddr_a),
		.vtx_raddr_b (vtx_raddr_b),
		.vtx_rdist_a (vtx_rdist_a),
		.vtx_rpred_a (vtx_rpred_a),
		.vtx_rdist_b (vtx_rdist_b)
	);

endmodule
